// ----- design/ssa_pkg.sv -----
package ssa_pkg;

    localparam int MAX_SKETCH = 256;
    localparam int MAX_DIM    = 128;
    localparam int MAX_KEYS   = 64;
    localparam int KV_HEADS   = 4;

    localparam int ACC_W      = 24;
    localparam int SUM_W      = 38;
    localparam int NORM_W     = 20;
    localparam int LANE_W     = 32;
    localparam int COL_W      = 7;
    localparam int KADDR_W    = 8;
    localparam int KWORD_W    = MAX_SKETCH + NORM_W;

    localparam int NUMER_W    = 64;
    localparam int QUO_W      = 59;
    localparam int REM_W      = 24;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = 19;
    localparam int DIV_STEPS  = 59;

    typedef enum logic [1:0] {
        FN_PROJ  = 2'd0,
        FN_KEY   = 2'd1,
        FN_QUERY = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_SKETCH_BITS   = 3'd0,
        CFG_VECTOR_LENGTH = 3'd1,
        CFG_QUERY_HEADS   = 3'd2,
        CFG_SHARED_HEADS  = 3'd3,
        CFG_SCORE_SCALE   = 3'd4,
        CFG_KEYS_IN_USE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQ_START,
        ST_SQ_RUN,
        ST_KREAD,
        ST_HAM,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic               sqrt;
        logic [NUMER_W-1:0] numer;
        logic [3:0]         divisor;
    } iter_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } iter_stat_t;

endpackage

// ----- design/sign_sketch_attention_scorer.sv -----
// key or query element: input not ready while it is accumulated
// last element of a vector adds the bit-serial norm root
// each score: sketch compare, three multiplies, 59-step divide
// one output register: the next score is computed while a result waits
// rst_n async: control and config to defaults, accumulators cleared, memories undefined
module sign_sketch_attention_scorer
    import ssa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // head, key_slot, proj_row, proj_col, proj_positive, element, zero pad
    input  logic [47:0] s_axis_tdata,
    // func
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scored_slot, hamming, score, zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [8:0]  sketch_bits_reg;
    logic [7:0]  vector_length_reg;
    logic [4:0]  query_heads_reg;
    logic [2:0]  shared_heads_reg;
    logic [15:0] score_scale_reg;
    logic [6:0]  keys_in_use_reg;

    logic signed [ACC_W-1:0] acc_reg [MAX_SKETCH];
    logic [SUM_W-1:0]        sum_reg;
    logic [COL_W-1:0]        count_reg;

    func_t              func_reg;
    logic [3:0]         head_reg;
    logic [5:0]         slot_reg;
    logic signed [15:0] elem_reg;
    logic               last_reg;

    logic [MAX_SKETCH-1:0] sk_reg;
    logic [NORM_W-1:0]     qn_reg;
    logic [1:0]            kv_reg;
    logic [5:0]            k_reg;
    logic [2:0]            w_reg;
    logic [8:0]            h_reg;
    logic                  neg_reg;
    logic [8:0]            d_reg;
    logic [39:0]           p40_reg;
    logic [55:0]           t_reg;
    logic [63:0]           p_reg;

    logic        out_valid_reg;
    logic [5:0]  out_slot_reg;
    logic [8:0]  out_ham_reg;
    logic [31:0] out_score_reg;
    logic        out_last_reg;

    logic [MAX_SKETCH-1:0] proj_rdata;
    logic [KWORD_W-1:0]    key_rdata;
    iter_ctrl_t            iter_ctrl;
    iter_stat_t            iter_stat;

    logic                  in_fire;
    logic                  out_fire;
    logic [8:0]            m_eff;
    logic [3:0]            m_words;
    logic [7:0]            vlen;
    logic [4:0]            qh;
    logic [2:0]            kvh;
    logic [6:0]            nk;
    logic [4:0]            grp;
    logic [4:0]            kv;
    logic                  col_ok;
    logic                  query_ok;
    logic                  key_ok;
    logic                  last_key;
    logic                  word_last;
    logic                  emit_go;
    logic [MAX_SKETCH-1:0] sketch;
    logic [31:0]           cmp_word;
    logic [5:0]            cmp_pop;
    logic [31:0]           e_sq;
    logic [59:0]           rounded;
    logic [35:0]           mag;
    logic [31:0]           mag_sat;

    function automatic logic [4:0] div_small(input logic [4:0] n, input logic [4:0] d);
        logic [4:0] q;
        logic [9:0] prod;
        q = '0;
        for (int i = 1; i <= 16; i++)
        begin
            prod = 10'(i) * {5'b0, d};
            if (prod <= {5'b0, n})
            begin
                q = 5'(i);
            end
        end
        return q;
    endfunction

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < LANE_W; i++)
        begin
            c = c + {5'b0, v[i]};
        end
        return c;
    endfunction

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_valid_reg && m_axis_tready;

    // effective configuration
    always_comb
    begin
        m_eff = {sketch_bits_reg[8:5], 5'b0};
        if (m_eff < 9'd32)
        begin
            m_eff = 9'd32;
        end
        else if (m_eff > 9'(MAX_SKETCH))
        begin
            m_eff = 9'(MAX_SKETCH);
        end
        m_words = m_eff[8:5];

        vlen = vector_length_reg;
        if (vlen == 8'd0)
        begin
            vlen = 8'd1;
        end
        else if (vlen > 8'(MAX_DIM))
        begin
            vlen = 8'(MAX_DIM);
        end

        qh = query_heads_reg;
        if (qh == 5'd0)
        begin
            qh = 5'd1;
        end
        else if (qh > 5'd16)
        begin
            qh = 5'd16;
        end

        kvh = shared_heads_reg;
        if (kvh == 3'd0)
        begin
            kvh = 3'd1;
        end
        else if (kvh > 3'(KV_HEADS))
        begin
            kvh = 3'(KV_HEADS);
        end

        nk = keys_in_use_reg;
        if (nk == 7'd0)
        begin
            nk = 7'd1;
        end
        else if (nk > 7'(MAX_KEYS))
        begin
            nk = 7'(MAX_KEYS);
        end

        grp = div_small(qh, {2'b0, kvh});
        if (grp == 5'd0)
        begin
            grp = 5'd1;
        end
        kv = div_small({1'b0, head_reg}, grp);
    end

    assign col_ok    = {1'b0, count_reg} < vlen;
    assign key_ok    = {1'b0, head_reg} < kvh;
    assign query_ok  = ({1'b0, head_reg} < qh) && (kv < {2'b0, kvh});
    assign last_key  = ({1'b0, k_reg} + 7'd1) == nk;
    assign word_last = {1'b0, w_reg} == (m_words - 4'd1);
    assign emit_go   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        for (int r = 0; r < MAX_SKETCH; r++)
        begin
            sketch[r] = !acc_reg[r][ACC_W-1] && (9'(r) < m_eff);
        end
    end

    assign cmp_word = sk_reg[w_reg*LANE_W +: LANE_W] ^ key_rdata[w_reg*LANE_W +: LANE_W];
    assign cmp_pop  = pop32(cmp_word);
    assign e_sq     = 32'(elem_reg * elem_reg);

    // round the Q35.24 quotient half up to an integer, then saturate on the sign
    always_comb
    begin
        rounded = {1'b0, iter_stat.quo} + 60'(1 << 23);
        mag     = rounded[59:24];
        if (!neg_reg && mag > 36'h07FFFFFFF)
        begin
            mag_sat = 32'h7FFFFFFF;
        end
        else if (neg_reg && mag > 36'h080000000)
        begin
            mag_sat = 32'h80000000;
        end
        else
        begin
            mag_sat = mag[31:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        iter_ctrl.start   = 1'b0;
        iter_ctrl.sqrt    = 1'b1;
        iter_ctrl.numer   = {sum_reg, {(NUMER_W-SUM_W){1'b0}}};
        iter_ctrl.divisor = m_words;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser == FN_KEY || s_axis_tuser == FN_QUERY))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_SQ_START : ST_IDLE;
            end
            ST_SQ_START:
            begin
                iter_ctrl.start = 1'b1;
                state_next      = ST_SQ_RUN;
            end
            ST_SQ_RUN:
            begin
                if (iter_stat.done)
                begin
                    if (func_reg == FN_QUERY && query_ok)
                    begin
                        state_next = ST_KREAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_KREAD:
            begin
                state_next = ST_HAM;
            end
            ST_HAM:
            begin
                if (word_last)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                iter_ctrl.start = 1'b1;
                iter_ctrl.sqrt  = 1'b0;
                iter_ctrl.numer = {p_reg[63:5], 5'b0};
                state_next      = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (iter_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = last_key ? ST_IDLE : ST_KREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sketch_bits_reg   <= 9'd256;
            vector_length_reg <= 8'd128;
            query_heads_reg   <= 5'd16;
            shared_heads_reg  <= 3'd4;
            score_scale_reg   <= 16'hFFFF;
            keys_in_use_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SKETCH_BITS:   sketch_bits_reg   <= cfg_data[8:0];
                CFG_VECTOR_LENGTH: vector_length_reg <= cfg_data[7:0];
                CFG_QUERY_HEADS:   query_heads_reg   <= cfg_data[4:0];
                CFG_SHARED_HEADS:  shared_heads_reg  <= cfg_data[2:0];
                CFG_SCORE_SCALE:   score_scale_reg   <= cfg_data;
                CFG_KEYS_IN_USE:   keys_in_use_reg   <= cfg_data[6:0];
                default:           ;
            endcase
        end
    end

    // accumulator lanes and running square sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_SKETCH; r++)
            begin
                acc_reg[r] <= '0;
            end
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            if (col_ok)
            begin
                for (int r = 0; r < MAX_SKETCH; r++)
                begin
                    acc_reg[r] <= proj_rdata[r] ? acc_reg[r] + ACC_W'(elem_reg)
                                                : acc_reg[r] - ACC_W'(elem_reg);
                end
                sum_reg <= sum_reg + {6'b0, e_sq};
            end
            count_reg <= count_reg + 1'b1;
        end
        else if (state_reg == ST_SQ_START)
        begin
            for (int r = 0; r < MAX_SKETCH; r++)
            begin
                acc_reg[r] <= '0;
            end
            sum_reg   <= '0;
            count_reg <= '0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_reg <= func_t'(s_axis_tuser);
                    head_reg <= s_axis_tdata[3:0];
                    slot_reg <= s_axis_tdata[9:4];
                    elem_reg <= s_axis_tdata[41:26];
                    last_reg <= s_axis_tlast;
                end
            end
            ST_SQ_START:
            begin
                sk_reg <= sketch;
            end
            ST_SQ_RUN:
            begin
                if (iter_stat.done)
                begin
                    qn_reg <= iter_stat.quo[NORM_W-1:0];
                    kv_reg <= kv[1:0];
                    k_reg  <= '0;
                end
            end
            ST_KREAD:
            begin
                w_reg <= '0;
                h_reg <= '0;
            end
            ST_HAM:
            begin
                h_reg <= h_reg + {3'b0, cmp_pop};
                w_reg <= w_reg + 1'b1;
            end
            ST_MUL1:
            begin
                p40_reg <= qn_reg * key_rdata[KWORD_W-1 -: NORM_W];
                neg_reg <= {h_reg, 1'b0} > {1'b0, m_eff};
                d_reg   <= ({h_reg, 1'b0} > {1'b0, m_eff})
                           ? 9'({h_reg, 1'b0} - {1'b0, m_eff})
                           : 9'({1'b0, m_eff} - {h_reg, 1'b0});
            end
            ST_MUL2:
            begin
                t_reg <= p40_reg * score_scale_reg;
            end
            ST_MUL3:
            begin
                p_reg <= 64'(t_reg * d_reg);
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_slot_reg  <= k_reg;
                    out_ham_reg   <= h_reg;
                    out_score_reg <= neg_reg ? 32'(0) - mag_sat : mag_sat;
                    out_last_reg  <= last_key;
                    k_reg         <= k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_score_reg, out_ham_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

    ssa_proj_ram u_proj_ram (
        .clk   (clk),
        .we    (in_fire && s_axis_tuser == FN_PROJ),
        .waddr (s_axis_tdata[24:18]),
        .wbit  (s_axis_tdata[17:10]),
        .wdata (s_axis_tdata[25]),
        .raddr (count_reg),
        .rdata (proj_rdata)
    );

    ssa_key_ram u_key_ram (
        .clk   (clk),
        .we    (state_reg == ST_SQ_RUN && iter_stat.done && func_reg == FN_KEY && key_ok),
        .waddr ({head_reg[1:0], slot_reg}),
        .wdata ({iter_stat.quo[NORM_W-1:0], sk_reg}),
        .raddr ({kv_reg, k_reg}),
        .rdata (key_rdata)
    );

    ssa_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (iter_ctrl),
        .stat  (iter_stat)
    );

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !iter_stat.busy)
        else $error("input ready while the shared unit runs");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_score_reg))
        else $error("pending score lost");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && emit_go && last_key |=> state_reg == ST_IDLE)
        else $error("burst did not end on its last key");

endmodule

// ----- design/ssa_proj_ram.sv -----
module ssa_proj_ram
    import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [COL_W-1:0]      waddr,
    input  logic [7:0]            wbit,
    input  logic                  wdata,
    input  logic [COL_W-1:0]      raddr,
    output logic [MAX_SKETCH-1:0] rdata
);

    // one column per entry, one bit per projection row
    logic [MAX_SKETCH-1:0] mem [MAX_DIM];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wbit] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ssa_key_ram.sv -----
module ssa_key_ram
    import ssa_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [KADDR_W-1:0] waddr,
    input  logic [KWORD_W-1:0] wdata,
    input  logic [KADDR_W-1:0] raddr,
    output logic [KWORD_W-1:0] rdata
);

    // norm in the top bits, sketch below
    logic [KWORD_W-1:0] mem [KV_HEADS*MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ssa_iter_unit.sv -----
module ssa_iter_unit
    import ssa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  iter_ctrl_t ctrl,
    output iter_stat_t stat
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sqrt_reg, sqrt_next;
    logic [NUMER_W-1:0] num_reg, num_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [3:0]         div_reg, div_next;

    logic [REM_W-1:0]   shifted;
    logic [REM_W-1:0]   trial;
    logic               ge;

    // shared shift / compare / subtract step: restoring root or division
    always_comb
    begin
        shifted = sqrt_reg ? {rem_reg[REM_W-3:0], num_reg[NUMER_W-1 -: 2]}
                           : {rem_reg[REM_W-2:0], num_reg[NUMER_W-1]};
        trial   = sqrt_reg ? {quo_reg[REM_W-3:0], 2'b01}
                           : {{(REM_W-4){1'b0}}, div_reg};
        ge      = shifted >= trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            sqrt_next = ctrl.sqrt;
            num_next  = ctrl.numer;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = ctrl.sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
            div_next  = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? shifted - trial : shifted;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            num_next = sqrt_reg ? {num_reg[NUMER_W-3:0], 2'b00}
                                : {num_reg[NUMER_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("iterative unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a running operation");

    a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && sqrt_reg |-> quo_reg[QUO_W-1:NORM_W] == '0)
        else $error("root wider than a norm");

endmodule
